// File: hw/rtl/pattern_occurrence_counter_unit_defines.svh
// ---------------------------------------------------------------------------
// Pattern occurrence counter assertion macros
// Shared concurrent assertion forms for the port-level checker.
// ---------------------------------------------------------------------------
`ifndef PATTERN_OCCURRENCE_COUNTER_UNIT_DEFINES_SVH
`define PATTERN_OCCURRENCE_COUNTER_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock edge.
`define POC_ASSERT_SAME(label, clk, dis, ante, cons) \
    label: assert property (@(posedge clk) disable iff (dis) (ante) |-> (cons)) \
        else $error("pattern occurrence counter: same-cycle check failed");

// Next-cycle implication, sampled on the rising clock edge.
`define POC_ASSERT_NEXT(label, clk, dis, ante, cons) \
    label: assert property (@(posedge clk) disable iff (dis) (ante) |=> (cons)) \
        else $error("pattern occurrence counter: next-cycle check failed");

`endif

// File: hw/rtl/poc_pkg.sv
// ---------------------------------------------------------------------------
// Pattern occurrence counter package
// Sizes, register indexes and control structs shared by the counter modules.
// ---------------------------------------------------------------------------
`default_nettype none

package poc_pkg;

    localparam int PATTERN_MAX = 16;
    localparam int COUNT_WIDTH = 16;

    // The pattern registers hold sixteen bytes whatever PATTERN_MAX is.
    localparam int PAT_BYTES  = 16;
    localparam int PAT_IDX_W  = 4;
    localparam int LEN_W      = 5;
    localparam int HIST_DEPTH = PATTERN_MAX - 1;
    localparam int SEEN_W     = $clog2(PATTERN_MAX + 1);
    localparam int BLK_W      = 4;
    localparam int OUT_CNT_W  = 16;

    localparam int APB_ADDR_W = 5;
    localparam int APB_DATA_W = 64;

    typedef enum logic [1:0] {
        REG_PATTERN_LOW  = 2'd0,
        REG_PATTERN_HIGH = 2'd1,
        REG_PATTERN_LEN  = 2'd2,
        REG_UNUSED       = 2'd3
    } poc_reg_idx_t;

    // Per-transaction control handed to the history cells and the tally.
    typedef struct packed {
        logic advance;   // an input transaction is accepted this cycle
        logic clear;     // it is the last byte of the text
    } poc_step_ctl_t;

    typedef struct packed {
        logic                   counted;
        logic [OUT_CNT_W-1:0]   count;
    } poc_tally_out_t;

endpackage

`default_nettype wire

// File: hw/rtl/pattern_occurrence_counter_unit.sv
// ---------------------------------------------------------------------------
// Pattern occurrence counter unit
// Counts non-overlapping occurrences of a configured pattern in a byte stream.
// ---------------------------------------------------------------------------
//  Channel   Prefix  Direction  Contents
//  text      s_      in         text_byte, end_of_text
//  result    m_      out        match_counted, occurrence_count, final_result
//  config    p       in/out     APB, 64-bit data, registers at 0x00/0x08/0x10
//
//  One byte is taken every cycle while s_ready is high; its result is registered
//  from the combinational window compare across the history cell chain.
//  A two-entry output (register plus skid) lets one more transaction enter
//  while a result waits; s_ready falls only when both entries are full.
//  Reset (synchronous, aresetn low) clears registers, history and count.
// ---------------------------------------------------------------------------
`default_nettype none

module pattern_occurrence_counter_unit
    import poc_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  s_valid,
    output logic                       s_ready,
    input  wire logic [7:0]            s_text_byte,
    input  wire logic                  s_end_of_text,
    output logic                       m_valid,
    input  wire logic                  m_ready,
    output logic                       m_match_counted,
    output logic [OUT_CNT_W-1:0]       m_occurrence_count,
    output logic                       m_final_result,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [APB_ADDR_W-1:0] paddr,
    input  wire logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0]      prdata,
    output logic                       pready
);

    // Configuration registers.
    logic [63:0]      pat_low_reg;
    logic [63:0]      pat_high_reg;
    logic [LEN_W-1:0] pat_len_reg;
    poc_reg_idx_t     reg_idx;
    logic             cfg_write;

    assign pready    = 1'b1;
    assign reg_idx   = poc_reg_idx_t'(paddr[4:3]);
    assign cfg_write = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pat_low_reg  <= '0;
            pat_high_reg <= '0;
            pat_len_reg  <= '0;
        end else if (cfg_write) begin
            unique case (reg_idx)
                REG_PATTERN_LOW:  pat_low_reg  <= pwdata;
                REG_PATTERN_HIGH: pat_high_reg <= pwdata;
                REG_PATTERN_LEN:  pat_len_reg  <= pwdata[LEN_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_PATTERN_LOW:  prdata = pat_low_reg;
            REG_PATTERN_HIGH: prdata = pat_high_reg;
            REG_PATTERN_LEN:  prdata = APB_DATA_W'(pat_len_reg);
            default:          prdata = '0;
        endcase
    end

    // Pattern bytes and the effective length.
    logic [7:0]           pat_bytes [PAT_BYTES];
    logic [LEN_W-1:0]     len;
    logic [PAT_IDX_W-1:0] len_m1;

    always_comb begin
        for (int k = 0; k < 8; k++) begin
            pat_bytes[k]     = pat_low_reg[8*k +: 8];
            pat_bytes[k + 8] = pat_high_reg[8*k +: 8];
        end
    end

    assign len    = (pat_len_reg > LEN_W'(PATTERN_MAX)) ? LEN_W'(PATTERN_MAX) : pat_len_reg;
    assign len_m1 = PAT_IDX_W'(len - 1'b1);

    // Input handshake and per-step control.
    logic          skid_valid_reg;
    logic          accept;
    poc_step_ctl_t ctl;

    assign s_ready     = !skid_valid_reg;
    assign accept      = s_valid && s_ready;
    assign ctl.advance = accept;
    assign ctl.clear   = s_end_of_text;

    // History cell chain: cell g holds the byte g+1 positions back.
    logic [7:0] cell_byte [HIST_DEPTH];
    logic [HIST_DEPTH-1:0] cell_hit;

    genvar g;
    generate
        for (g = 0; g < HIST_DEPTH; g++) begin : g_cell
            logic [7:0] shift_in;
            logic [7:0] want_byte;
            logic       active;

            if (g == 0) begin : g_head
                assign shift_in = s_text_byte;
            end else begin : g_body
                assign shift_in = cell_byte[g-1];
            end

            assign want_byte = pat_bytes[PAT_IDX_W'(len_m1 - PAT_IDX_W'(g + 1))];
            assign active    = (LEN_W'(g + 1) < len);

            poc_cell u_cell (
                .aclk      (aclk),
                .aresetn   (aresetn),
                .ctl       (ctl),
                .shift_in  (shift_in),
                .want_byte (want_byte),
                .active    (active),
                .byte_q    (cell_byte[g]),
                .hit       (cell_hit[g])
            );
        end
    endgenerate

    logic           window_hit;
    poc_tally_out_t tally;

    assign window_hit = (s_text_byte == pat_bytes[len_m1]) && (&cell_hit);

    poc_tally u_tally (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .ctl        (ctl),
        .window_hit (window_hit),
        .len        (len),
        .result     (tally)
    );

    // Output register with a skid entry behind it.
    logic                 out_valid_reg;
    logic                 out_match_reg, skid_match_reg;
    logic [OUT_CNT_W-1:0] out_count_reg, skid_count_reg;
    logic                 out_final_reg, skid_final_reg;
    logic                 out_fire;

    assign out_fire = out_valid_reg && m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            priority if (skid_valid_reg) begin
                if (out_fire) begin
                    skid_valid_reg <= 1'b0;
                end
            end else if (accept) begin
                if (out_valid_reg && !m_ready) begin
                    skid_valid_reg <= 1'b1;
                end else begin
                    out_valid_reg <= 1'b1;
                end
            end else if (out_fire) begin
                out_valid_reg <= 1'b0;
            end else begin
                out_valid_reg <= out_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        priority if (skid_valid_reg) begin
            if (out_fire) begin
                out_match_reg <= skid_match_reg;
                out_count_reg <= skid_count_reg;
                out_final_reg <= skid_final_reg;
            end
        end else if (accept) begin
            if (out_valid_reg && !m_ready) begin
                skid_match_reg <= tally.counted;
                skid_count_reg <= tally.count;
                skid_final_reg <= s_end_of_text;
            end else begin
                out_match_reg <= tally.counted;
                out_count_reg <= tally.count;
                out_final_reg <= s_end_of_text;
            end
        end else begin
            out_match_reg <= out_match_reg;
            out_count_reg <= out_count_reg;
            out_final_reg <= out_final_reg;
        end
    end

    assign m_valid            = out_valid_reg;
    assign m_match_counted    = out_match_reg;
    assign m_occurrence_count = out_count_reg;
    assign m_final_result     = out_final_reg;

endmodule

`default_nettype wire

// File: hw/rtl/poc_cell.sv
// ---------------------------------------------------------------------------
// Pattern occurrence counter history cell
// Holds one earlier text byte, passes it down the chain and compares it.
// ---------------------------------------------------------------------------
`default_nettype none

module poc_cell
    import poc_pkg::*;
(
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire poc_step_ctl_t ctl,
    input  wire logic [7:0]    shift_in,
    input  wire logic [7:0]    want_byte,
    input  wire logic          active,
    output logic [7:0]         byte_q,
    output logic               hit
);

    logic [7:0] byte_reg;
    logic [7:0] byte_next;

    always_comb begin
        byte_next = byte_reg;
        if (ctl.advance) begin
            byte_next = ctl.clear ? 8'd0 : shift_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            byte_reg <= 8'd0;
        end else begin
            byte_reg <= byte_next;
        end
    end

    assign byte_q = byte_reg;
    // A cell beyond the pattern length does not take part in the compare.
    assign hit    = !active || (byte_reg == want_byte);

endmodule

`default_nettype wire

// File: hw/rtl/poc_tally.sv
// ---------------------------------------------------------------------------
// Pattern occurrence counter tally
// Tracks bytes seen, the overlap block-out and the saturating count.
// ---------------------------------------------------------------------------
`default_nettype none

module poc_tally
    import poc_pkg::*;
(
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire poc_step_ctl_t    ctl,
    input  wire logic             window_hit,
    input  wire logic [LEN_W-1:0] len,
    output poc_tally_out_t        result
);

    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};

    logic [SEEN_W-1:0]      seen_reg, seen_next;
    logic [BLK_W-1:0]       blocked_reg, blocked_next;
    logic [COUNT_WIDTH-1:0] count_reg, count_next;
    logic [COUNT_WIDTH-1:0] count_step;
    logic                   enough;
    logic                   match;
    logic                   counted;

    // The whole pattern must lie inside the current text.
    assign enough = (6'(seen_reg) + 6'd1) >= 6'(len);
    assign match  = (len != '0) && enough && window_hit;

    always_comb begin
        blocked_next = blocked_reg;
        count_step   = count_reg;
        counted      = 1'b0;
        priority if (blocked_reg != '0) begin
            blocked_next = blocked_reg - 1'b1;
        end else if (match) begin
            counted      = 1'b1;
            if (count_reg != COUNT_MAX) begin
                count_step = count_reg + 1'b1;
            end
            blocked_next = BLK_W'(len - 1'b1);
        end else begin
            blocked_next = blocked_reg;
        end
    end

    always_comb begin
        seen_next  = seen_reg;
        count_next = count_reg;
        if (ctl.advance) begin
            if (ctl.clear) begin
                seen_next    = '0;
                count_next   = '0;
            end else begin
                count_next = count_step;
                if (seen_reg != SEEN_W'(PATTERN_MAX)) begin
                    seen_next = seen_reg + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seen_reg    <= '0;
            blocked_reg <= '0;
            count_reg   <= '0;
        end else begin
            seen_reg  <= seen_next;
            count_reg <= count_next;
            if (ctl.advance) begin
                blocked_reg <= ctl.clear ? '0 : blocked_next;
            end
        end
    end

    assign result.counted = counted;
    assign result.count   = OUT_CNT_W'(count_step);

endmodule

`default_nettype wire

// File: hw/rtl/poc_checker.sv
// ---------------------------------------------------------------------------
// Pattern occurrence counter checker
// Port-level assertions, bound to the top level.
// ---------------------------------------------------------------------------
`default_nettype none

`include "pattern_occurrence_counter_unit_defines.svh"

module poc_checker
    import poc_pkg::*;
(
    input wire logic                  aclk,
    input wire logic                  aresetn,
    input wire logic                  s_ready,
    input wire logic                  m_valid,
    input wire logic                  m_ready,
    input wire logic                  m_match_counted,
    input wire logic [OUT_CNT_W-1:0]  m_occurrence_count,
    input wire logic                  m_final_result
);

    // No result is offered right after reset.
    `POC_ASSERT_NEXT(a_no_result_after_reset, aclk, 1'b0, !aresetn, !m_valid)

    // A stalled result keeps its contents until it is taken.
    `POC_ASSERT_NEXT(a_result_holds, aclk, !aresetn, m_valid && !m_ready, m_valid && $stable(m_occurrence_count) && $stable(m_match_counted) && $stable(m_final_result))

    // Input back-pressure only appears while a result is waiting.
    `POC_ASSERT_SAME(a_stall_needs_result, aclk, !aresetn, !s_ready, m_valid)

    // A counted occurrence never shows a zero count.
    `POC_ASSERT_SAME(a_counted_nonzero, aclk, !aresetn, m_valid && m_match_counted, m_occurrence_count != '0)

endmodule

bind pattern_occurrence_counter_unit poc_checker u_poc_checker (.*);

`default_nettype wire
